>>> rtl/slc_pkg.sv
// Shared types, constants and helpers for the source line classifier.
// Used by slc_front, slc_queue, slc_back and source_line_classifier.
`default_nettype none

package slc_pkg;

  localparam int DELIM_MAX   = 3;
  localparam int FILL_W      = $clog2(DELIM_MAX + 1);
  localparam int LEN_W       = 2;
  localparam int PAT_W       = 8 * DELIM_MAX;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CNT_W       = 32;
  localparam int CLS_W       = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [7:0] byte_t;
  typedef byte_t [DELIM_MAX-1:0] win_t;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_BYTES  = 3'd0,
    CFG_LINE_LEN    = 3'd1,
    CFG_OPEN_BYTES  = 3'd2,
    CFG_OPEN_LEN    = 3'd3,
    CFG_CLOSE_BYTES = 3'd4,
    CFG_CLOSE_LEN   = 3'd5
  } cfg_idx_e;

  localparam logic [PAT_W-1:0] LINE_BYTES_RST  = 24'd12079;  // "//"
  localparam logic [PAT_W-1:0] OPEN_BYTES_RST  = 24'd10799;  // "/*"
  localparam logic [PAT_W-1:0] CLOSE_BYTES_RST = 24'd12074;  // "*/"
  localparam logic [LEN_W-1:0] DELIM_LEN_RST   = 2'd2;

  // Line classes
  localparam logic [CLS_W-1:0] CLS_CODE    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_COMMENT = 2'd1;
  localparam logic [CLS_W-1:0] CLS_BLANK   = 2'd2;

  // Characters of interest
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_VT     = 8'h0B;
  localparam byte_t CH_FF     = 8'h0C;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_DQUOTE = 8'h22;
  localparam byte_t CH_SQUOTE = 8'h27;
  localparam byte_t CH_BSLASH = 8'h5C;

  // Delimiter lengths, held steady while the block is idle
  typedef struct packed {
    logic [LEN_W-1:0] line_len;
    logic [LEN_W-1:0] open_len;
    logic [LEN_W-1:0] close_len;
  } dlen_t;

  // One examined byte, with its delimiter matches already resolved
  typedef struct packed {
    byte_t c;
    logic  m_open;
    logic  m_close;
    logic  m_line;
    logic  eof;   // last byte of the file: close the final line, clear state
    logic  last;  // any result of this op ends the input beat's results
  } op_t;

  function automatic logic delim_hit(win_t w, logic [PAT_W-1:0] pat,
                                     logic [LEN_W-1:0] len, logic [FILL_W-1:0] avail);
    logic hit;
    hit = (len != '0) && (int'(len) <= DELIM_MAX) && (int'(len) <= int'(avail));
    for (int k = 0; k < DELIM_MAX; k++) begin
      if ((k < int'(len)) && (w[k] != pat[8*k +: 8])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

>>> rtl/slc_front.sv
// Front end: configuration registers, lookahead window and delimiter matching.
// Emits one examine op per byte into the queue; depends on slc_pkg.
`default_nettype none

module slc_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [7:0]                      in_text_byte,
  input  wire logic                            in_end_of_text,
  input  wire logic                            cfg_we,
  input  wire logic [slc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [slc_pkg::CFG_W-1:0]       cfg_data,
  output      logic                            q_push,
  output      slc_pkg::op_t                    q_op,
  input  wire logic                            q_full,
  output      slc_pkg::dlen_t                  dlen
);

  logic [slc_pkg::PAT_W-1:0] line_bytes_r, open_bytes_r, close_bytes_r;
  logic [slc_pkg::LEN_W-1:0] line_len_r, open_len_r, close_len_r;

  slc_pkg::win_t              win_r, win_nxt, win_in, op_win;
  logic [slc_pkg::FILL_W-1:0] fill_r, fill_nxt, fill_in, op_avail;
  logic                       flush_r, flush_nxt;
  logic                       accept;

  function automatic slc_pkg::win_t shift_win(slc_pkg::win_t w);
    slc_pkg::win_t s;
    for (int k = 0; k < slc_pkg::DELIM_MAX; k++) begin
      s[k] = (k + 1 < slc_pkg::DELIM_MAX) ? w[k+1] : '0;
    end
    return s;
  endfunction

  assign in_ready = !flush_r && !q_full;
  assign accept   = in_valid && in_ready;

  assign dlen.line_len  = line_len_r;
  assign dlen.open_len  = open_len_r;
  assign dlen.close_len = close_len_r;

  always_comb begin
    win_in = win_r;
    if (fill_r != slc_pkg::FILL_W'(slc_pkg::DELIM_MAX)) begin
      win_in[fill_r] = in_text_byte;
    end
    fill_in = fill_r + 1'b1;

    // During a flush the stored window drains; otherwise the incoming byte completes it
    op_win   = flush_r ? win_r : win_in;
    op_avail = flush_r ? fill_r : slc_pkg::FILL_W'(slc_pkg::DELIM_MAX);

    q_op.c       = op_win[0];
    q_op.m_open  = slc_pkg::delim_hit(op_win, open_bytes_r, open_len_r, op_avail);
    q_op.m_close = slc_pkg::delim_hit(op_win, close_bytes_r, close_len_r, op_avail);
    q_op.m_line  = slc_pkg::delim_hit(op_win, line_bytes_r, line_len_r, op_avail);
    q_op.eof     = flush_r && (fill_r == slc_pkg::FILL_W'(1));
    q_op.last    = !flush_r || (fill_r == slc_pkg::FILL_W'(1));

    win_nxt   = win_r;
    fill_nxt  = fill_r;
    flush_nxt = flush_r;
    q_push    = 1'b0;

    if (flush_r) begin
      if (!q_full) begin
        q_push   = 1'b1;
        win_nxt  = shift_win(win_r);
        fill_nxt = fill_r - 1'b1;
        if (fill_r == slc_pkg::FILL_W'(1)) begin
          flush_nxt = 1'b0;
        end
      end
    end else if (accept) begin
      if (in_end_of_text) begin
        win_nxt   = win_in;
        fill_nxt  = fill_in;
        flush_nxt = 1'b1;
      end else if (fill_in == slc_pkg::FILL_W'(slc_pkg::DELIM_MAX)) begin
        q_push   = 1'b1;
        win_nxt  = shift_win(win_in);
        fill_nxt = fill_in - 1'b1;
      end else begin
        win_nxt  = win_in;
        fill_nxt = fill_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r  <= slc_pkg::LINE_BYTES_RST;
      line_len_r    <= slc_pkg::DELIM_LEN_RST;
      open_bytes_r  <= slc_pkg::OPEN_BYTES_RST;
      open_len_r    <= slc_pkg::DELIM_LEN_RST;
      close_bytes_r <= slc_pkg::CLOSE_BYTES_RST;
      close_len_r   <= slc_pkg::DELIM_LEN_RST;
      win_r         <= '0;
      fill_r        <= '0;
      flush_r       <= 1'b0;
    end else begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      flush_r <= flush_nxt;
      if (cfg_we) begin
        unique case (slc_pkg::cfg_idx_e'(cfg_index))
          slc_pkg::CFG_LINE_BYTES:  line_bytes_r  <= cfg_data[slc_pkg::PAT_W-1:0];
          slc_pkg::CFG_LINE_LEN:    line_len_r    <= cfg_data[slc_pkg::LEN_W-1:0];
          slc_pkg::CFG_OPEN_BYTES:  open_bytes_r  <= cfg_data[slc_pkg::PAT_W-1:0];
          slc_pkg::CFG_OPEN_LEN:    open_len_r    <= cfg_data[slc_pkg::LEN_W-1:0];
          slc_pkg::CFG_CLOSE_BYTES: close_bytes_r <= cfg_data[slc_pkg::PAT_W-1:0];
          slc_pkg::CFG_CLOSE_LEN:   close_len_r   <= cfg_data[slc_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !flush_r |-> fill_r < slc_pkg::FILL_W'(slc_pkg::DELIM_MAX))
    else $error("window over-filled outside a flush");

  a_full_window_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_end_of_text && (fill_r == slc_pkg::FILL_W'(slc_pkg::DELIM_MAX - 1))
    |-> q_push)
    else $error("full window did not produce an examine op");

endmodule

`default_nettype wire

>>> rtl/slc_queue.sv
// Short FIFO of examine ops between the front end and the back end.
// Depends on slc_pkg for the op type and depth.
`default_nettype none

module slc_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire slc_pkg::op_t push_op,
  output      logic         full,
  input  wire logic         pop,
  output      logic         pop_valid,
  output      slc_pkg::op_t pop_op
);

  slc_pkg::op_t               slots_r [slc_pkg::QUEUE_DEPTH];
  logic [slc_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [slc_pkg::QPTR_W:0]   count_r, count_nxt;
  logic                       do_push, do_pop;

  assign full      = (count_r == (slc_pkg::QPTR_W+1)'(slc_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_op    = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

>>> rtl/slc_back.sv
// Back end: string and comment tracking, line classification and counters.
// Consumes examine ops from slc_queue; drives the registered result beat.
`default_nettype none

module slc_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire slc_pkg::op_t                 q_op,
  output      logic                         q_pop,
  input  wire slc_pkg::dlen_t               dlen,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [slc_pkg::CLS_W-1:0]    out_line_class,
  output      logic [slc_pkg::CNT_W-1:0]    out_code_total,
  output      logic [slc_pkg::CNT_W-1:0]    out_comment_total,
  output      logic [slc_pkg::CNT_W-1:0]    out_blank_total,
  output      logic [slc_pkg::CNT_W-1:0]    out_byte_total,
  output      logic                         out_file_done,
  output      logic                         out_run_last
);

  logic [slc_pkg::LEN_W-1:0] skip_r, skip_nxt, skip_x;
  logic blk_r, blk_nxt, blk_x;
  logic lcom_r, lcom_nxt, lcom_x;
  logic str_r, str_nxt, str_x;
  logic qs_r, qs_nxt, qs_x;
  logic code_r, code_nxt, code_x;
  slc_pkg::byte_t prev_r, prev_nxt, quote;
  logic [slc_pkg::CNT_W-1:0] code_cnt_r, code_cnt_nxt, cmt_cnt_r, cmt_cnt_nxt;
  logic [slc_pkg::CNT_W-1:0] blank_cnt_r, blank_cnt_nxt, byte_cnt_r, byte_cnt_nxt;
  logic [slc_pkg::CNT_W-1:0] byte_x, code_cnt_x, cmt_cnt_x, blank_cnt_x;
  logic [slc_pkg::CLS_W-1:0] cls;
  logic out_valid_r, out_valid_nxt;
  logic [slc_pkg::CLS_W-1:0] out_cls_r;
  logic [slc_pkg::CNT_W-1:0] out_code_r, out_cmt_r, out_blank_r, out_byte_r;
  logic out_done_r, out_last_r;
  logic take, nl, emit, is_cmt, is_code;

  function automatic logic [slc_pkg::CNT_W-1:0] sat_inc(logic [slc_pkg::CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic is_ws(slc_pkg::byte_t c);
    return (c == slc_pkg::CH_SPACE) || (c == slc_pkg::CH_TAB) || (c == slc_pkg::CH_VT) ||
           (c == slc_pkg::CH_FF) || (c == slc_pkg::CH_CR);
  endfunction

  assign take  = q_valid && (!out_valid_r || out_ready);
  assign q_pop = take;

  always_comb begin
    skip_x = skip_r;
    blk_x  = blk_r;
    lcom_x = lcom_r;
    str_x  = str_r;
    qs_x   = qs_r;
    code_x = code_r;
    nl     = 1'b0;
    quote  = qs_r ? slc_pkg::CH_SQUOTE : slc_pkg::CH_DQUOTE;
    byte_x = sat_inc(byte_cnt_r);

    if (skip_r != '0) begin
      skip_x = skip_r - 1'b1;
    end else if (q_op.c == slc_pkg::CH_LF) begin
      nl     = 1'b1;
      lcom_x = 1'b0;
      code_x = 1'b0;
    end else if (!is_ws(q_op.c)) begin
      if (!lcom_r && !blk_r) begin
        if (!str_r && (q_op.c == slc_pkg::CH_DQUOTE || q_op.c == slc_pkg::CH_SQUOTE)) begin
          str_x  = 1'b1;
          qs_x   = (q_op.c == slc_pkg::CH_SQUOTE);
          code_x = 1'b1;
        end else if (str_r && q_op.c == quote && prev_r != slc_pkg::CH_BSLASH) begin
          str_x = 1'b0;
        end
      end
      // Delimiter priority: block open, block close, line comment
      if (!str_x) begin
        if (!lcom_r && !blk_r && q_op.m_open) begin
          blk_x  = 1'b1;
          skip_x = dlen.open_len - 1'b1;
        end else if (blk_r && q_op.m_close) begin
          blk_x  = 1'b0;
          skip_x = dlen.close_len - 1'b1;
        end else if (!blk_r && !lcom_r && q_op.m_line) begin
          lcom_x = 1'b1;
          skip_x = dlen.line_len - 1'b1;
        end else if (!blk_r && !lcom_r) begin
          code_x = 1'b1;
        end
      end
    end

    // A newline classifies with the state before it; the end of text with the state after
    emit    = nl || q_op.eof;
    is_cmt  = nl ? (lcom_r || blk_r) : (lcom_x || blk_x);
    is_code = nl ? code_r : code_x;
    if (is_cmt) begin
      cls = slc_pkg::CLS_COMMENT;
    end else if (is_code) begin
      cls = slc_pkg::CLS_CODE;
    end else begin
      cls = slc_pkg::CLS_BLANK;
    end
    code_cnt_x  = (emit && cls == slc_pkg::CLS_CODE)    ? sat_inc(code_cnt_r)  : code_cnt_r;
    cmt_cnt_x   = (emit && cls == slc_pkg::CLS_COMMENT) ? sat_inc(cmt_cnt_r)   : cmt_cnt_r;
    blank_cnt_x = (emit && cls == slc_pkg::CLS_BLANK)   ? sat_inc(blank_cnt_r) : blank_cnt_r;

    skip_nxt      = skip_r;
    blk_nxt       = blk_r;
    lcom_nxt      = lcom_r;
    str_nxt       = str_r;
    qs_nxt        = qs_r;
    code_nxt      = code_r;
    prev_nxt      = prev_r;
    code_cnt_nxt  = code_cnt_r;
    cmt_cnt_nxt   = cmt_cnt_r;
    blank_cnt_nxt = blank_cnt_r;
    byte_cnt_nxt  = byte_cnt_r;
    if (take) begin
      if (q_op.eof) begin
        // Drop all file state so the next byte starts a new file
        skip_nxt      = '0;
        blk_nxt       = 1'b0;
        lcom_nxt      = 1'b0;
        str_nxt       = 1'b0;
        qs_nxt        = 1'b0;
        code_nxt      = 1'b0;
        prev_nxt      = '0;
        code_cnt_nxt  = '0;
        cmt_cnt_nxt   = '0;
        blank_cnt_nxt = '0;
        byte_cnt_nxt  = '0;
      end else begin
        skip_nxt      = skip_x;
        blk_nxt       = blk_x;
        lcom_nxt      = lcom_x;
        str_nxt       = str_x;
        qs_nxt        = qs_x;
        code_nxt      = code_x;
        prev_nxt      = q_op.c;
        code_cnt_nxt  = code_cnt_x;
        cmt_cnt_nxt   = cmt_cnt_x;
        blank_cnt_nxt = blank_cnt_x;
        byte_cnt_nxt  = byte_x;
      end
    end

    if (take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r      <= '0;
      blk_r       <= 1'b0;
      lcom_r      <= 1'b0;
      str_r       <= 1'b0;
      qs_r        <= 1'b0;
      code_r      <= 1'b0;
      prev_r      <= '0;
      code_cnt_r  <= '0;
      cmt_cnt_r   <= '0;
      blank_cnt_r <= '0;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      skip_r      <= skip_nxt;
      blk_r       <= blk_nxt;
      lcom_r      <= lcom_nxt;
      str_r       <= str_nxt;
      qs_r        <= qs_nxt;
      code_r      <= code_nxt;
      prev_r      <= prev_nxt;
      code_cnt_r  <= code_cnt_nxt;
      cmt_cnt_r   <= cmt_cnt_nxt;
      blank_cnt_r <= blank_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_cls_r   <= cls;
      out_code_r  <= code_cnt_x;
      out_cmt_r   <= cmt_cnt_x;
      out_blank_r <= blank_cnt_x;
      out_byte_r  <= byte_x;
      out_done_r  <= q_op.eof;
      out_last_r  <= q_op.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_class    = out_cls_r;
  assign out_code_total    = out_code_r;
  assign out_comment_total = out_cmt_r;
  assign out_blank_total   = out_blank_r;
  assign out_byte_total    = out_byte_r;
  assign out_file_done     = out_done_r;
  assign out_run_last      = out_last_r;

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_done_r || out_last_r))
    else $error("file_done result is not the last of its beat");

  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && q_op.eof |=> (byte_cnt_r == '0) && !blk_r && !str_r && !lcom_r)
    else $error("file state not cleared after end of text");

  a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(skip_r) < slc_pkg::DELIM_MAX)
    else $error("skip count exceeds delimiter length");

endmodule

`default_nettype wire

>>> rtl/source_line_classifier.sv
// Top level of the source line classifier: front end, op queue and back end.
// Depends on slc_pkg, slc_front, slc_queue and slc_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one text byte per beat; set
//   in_end_of_text on the last byte of a file. Each newline yields one result
//   beat on the output channel (out_valid/out_ready) with the line class and
//   saturating code, comment, blank and byte totals; the end of the file
//   yields a result for a still-open last line, flagged with out_file_done.
//   out_run_last marks the last result caused by an input beat.
//   Throughput: one byte per cycle while the op queue has room and no drain
//   is under way. A byte that completes the three-byte lookahead window sends
//   its oldest byte through the op queue to the back end; any result is
//   registered. An end-of-text byte drains the window one byte per cycle
//   while the queue has room; in_ready stays low until the window is empty.
//   Configuration: cfg_we/cfg_index/cfg_data write a delimiter or its length;
//   write only while the block is idle.
//   Reset: delimiters return to the C-style set, window and counts clear.
//   A stalled receiver holds the result register; a four-deep op queue keeps
//   accepting bytes until it fills, then in_ready drops.
`default_nettype none

module source_line_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [7:0]                    in_text_byte,
  input  wire logic                          in_end_of_text,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [slc_pkg::CLS_W-1:0]     out_line_class,
  output      logic [slc_pkg::CNT_W-1:0]     out_code_total,
  output      logic [slc_pkg::CNT_W-1:0]     out_comment_total,
  output      logic [slc_pkg::CNT_W-1:0]     out_blank_total,
  output      logic [slc_pkg::CNT_W-1:0]     out_byte_total,
  output      logic                          out_file_done,
  output      logic                          out_run_last,
  input  wire logic                          cfg_we,
  input  wire logic [slc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [slc_pkg::CFG_W-1:0]     cfg_data
);

  logic           push, full, pop, q_valid;
  slc_pkg::op_t   push_op, pop_op;
  slc_pkg::dlen_t dlen;

  slc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_push         (push),
    .q_op           (push_op),
    .q_full         (full),
    .dlen           (dlen)
  );

  slc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .full      (full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_op    (pop_op)
  );

  slc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_op              (pop_op),
    .q_pop             (pop),
    .dlen              (dlen),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_class    (out_line_class),
    .out_code_total    (out_code_total),
    .out_comment_total (out_comment_total),
    .out_blank_total   (out_blank_total),
    .out_byte_total    (out_byte_total),
    .out_file_done     (out_file_done),
    .out_run_last      (out_run_last)
  );

endmodule

`default_nettype wire
